[hdl/gsbt_pkg.sv]
// shared constants and codes for the grid sweep best tracker
package gsbt_pkg;

	localparam int NUM_DIMS_DEF   = 4;
	localparam int NUM_SLOTS_DEF  = 8;
	localparam int COORD_BITS_DEF = 16;

	localparam int LANE_BITS   = 16;
	localparam int LANE_DIMS   = 4;
	localparam int SCORE_BITS  = 32;
	localparam int COUNT_BITS  = 32;
	localparam int SLOT_BITS   = 3;
	localparam int ACTION_BITS = 2;
	localparam int DIMSEL_BITS = 3;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 64;

	localparam int S_TDATA_BITS = 32;
	localparam int S_TUSER_BITS = 5;
	localparam int M_TDATA_BITS = 128;
	localparam int M_TUSER_BITS = 2;

	typedef logic [ACTION_BITS-1:0]  action_t;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	localparam action_t ACT_RESTART = 2'd0;
	localparam action_t ACT_ADVANCE = 2'd1;
	localparam action_t ACT_REPORT  = 2'd2;
	localparam action_t ACT_READ    = 2'd3;

	localparam cfg_idx_t REG_DIM_LOWS    = 3'd0;
	localparam cfg_idx_t REG_DIM_HIGHS   = 3'd1;
	localparam cfg_idx_t REG_DIM_STEPS   = 3'd2;
	localparam cfg_idx_t REG_DIMS_IN_USE = 3'd3;

	localparam logic [CFG_DATA_BITS-1:0] DIM_STEPS_RST = 64'h0001_0001_0001_0001;
	localparam logic [DIMSEL_BITS-1:0]   DIMS_IN_USE_RST = 3'd4;

	localparam int USER_FINISHED = 0;
	localparam int USER_IMPROVED = 1;

endpackage

[hdl/gsbt_ram.sv]
// generic single-write, single-read ram with registered read data
module gsbt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/grid_sweep_best_tracker.sv]
// top level of the grid sweep generator with per-slot best score keeping
//
// items enter on the s_axis channel: tuser carries the action and the slot,
// tdata the signed q16.16 score. actions are restart, advance, report score
// and read best. every item gives exactly one result item on m_axis: tdata
// holds the four coordinates, the slot's best grade and the step count,
// tuser the finished and improved flags.
// registers are written on the cfg channel (index, 64-bit data), always
// ready; write them only while no item is in flight.
// one item is taken every cycle unless the output stalls. the slot bests
// live in a ram read at accept time and updated from stage 1; a write-back
// register forwards the last update to the next item, and a valid bit per
// slot makes restart clear all bests at once.
// s_axis_tready drops only while the output register holds a result that
// the receiver has not taken; then the whole pipeline holds.
// after reset the point is zero, bests and count are clear, lows and highs
// are zero, steps are one and four dimensions are in use.
module grid_sweep_best_tracker #(
	parameter int NUM_DIMS   = gsbt_pkg::NUM_DIMS_DEF,
	parameter int NUM_SLOTS  = gsbt_pkg::NUM_SLOTS_DEF,
	parameter int COORD_BITS = gsbt_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// score
	input  logic [gsbt_pkg::S_TDATA_BITS-1:0]  s_axis_tdata,
	// action, score_slot
	input  logic [gsbt_pkg::S_TUSER_BITS-1:0]  s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// coord_0, coord_1, coord_2, coord_3, best_grade, steps_taken
	output logic [gsbt_pkg::M_TDATA_BITS-1:0]  m_axis_tdata,
	// sweep_finished, improved
	output logic [gsbt_pkg::M_TUSER_BITS-1:0]  m_axis_tuser,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [gsbt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [gsbt_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	localparam int CB  = COORD_BITS;
	localparam int CW1 = COORD_BITS + 1;
	localparam int SB  = gsbt_pkg::SCORE_BITS;
	localparam int LB  = gsbt_pkg::LANE_BITS;
	localparam int AW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int EW  = SB + NUM_DIMS * COORD_BITS;

	typedef logic signed [CB-1:0] coord_t;

	// configuration
	logic [gsbt_pkg::CFG_DATA_BITS-1:0] lows_q, highs_q, steps_q;
	logic [gsbt_pkg::DIMSEL_BITS-1:0]   dims_q;

	// state
	coord_t                           pt_q [NUM_DIMS];
	logic [gsbt_pkg::COUNT_BITS-1:0]  cnt_q;
	logic [NUM_SLOTS-1:0]             vld_q;
	logic                             fwd_vld_q;
	logic [AW-1:0]                    fwd_addr_q;
	logic [EW-1:0]                    fwd_data_q;

	// stage 1
	logic                             vld_s1;
	gsbt_pkg::action_t                action_s1;
	logic [gsbt_pkg::SLOT_BITS-1:0]   slot_s1;
	logic signed [SB-1:0]             score_s1;

	// output register
	logic                             out_vld_q;
	logic [gsbt_pkg::M_TDATA_BITS-1:0] out_data_q;
	logic [gsbt_pkg::M_TUSER_BITS-1:0] out_user_q;

	logic                             adv, s_acc, proc;
	logic [EW-1:0]                    ram_rdata, rd_ent, ent, wr_ent;
	logic                             we, clr, fin, imp, slot_ok, fin_adv;
	logic [AW-1:0]                    addr_s1;
	logic signed [SB-1:0]             eff_score, grade;
	coord_t                           low_c [NUM_DIMS];
	coord_t                           high_c [NUM_DIMS];
	coord_t                           step_c [NUM_DIMS];
	logic signed [CW1-1:0]            nxt_c [NUM_DIMS];
	logic [NUM_DIMS-1:0]              can_c;
	coord_t                           pt_adv [NUM_DIMS];
	coord_t                           pt_nxt [NUM_DIMS];
	coord_t                           eff_pt [NUM_DIMS];
	coord_t                           out_pt [NUM_DIMS];
	logic [gsbt_pkg::COUNT_BITS-1:0]  cnt_nxt;
	logic [gsbt_pkg::DIMSEL_BITS-1:0] n_used;
	logic [gsbt_pkg::M_TDATA_BITS-1:0] res_data;
	logic                             carry;

	assign adv           = !out_vld_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign s_acc         = s_axis_tvalid && adv;
	assign proc          = vld_s1 && adv;
	assign cfg_ready     = 1'b1;

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	assign addr_s1 = AW'(slot_s1);
	assign slot_ok = int'(slot_s1) < NUM_SLOTS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lows_q  <= '0;
			highs_q <= '0;
			steps_q <= gsbt_pkg::DIM_STEPS_RST;
			dims_q  <= gsbt_pkg::DIMS_IN_USE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				gsbt_pkg::REG_DIM_LOWS:    lows_q  <= cfg_data;
				gsbt_pkg::REG_DIM_HIGHS:   highs_q <= cfg_data;
				gsbt_pkg::REG_DIM_STEPS:   steps_q <= cfg_data;
				gsbt_pkg::REG_DIMS_IN_USE: dims_q  <= cfg_data[gsbt_pkg::DIMSEL_BITS-1:0];
				default: ;
			endcase
		end
	end

	gsbt_ram #(
		.WIDTH(EW),
		.DEPTH(NUM_SLOTS)
	) u_best_ram (
		.clk   (clk),
		.we    (we && proc),
		.waddr (addr_s1),
		.wdata (wr_ent),
		.re    (s_acc),
		.raddr (AW'(s_axis_tuser[gsbt_pkg::ACTION_BITS +: gsbt_pkg::SLOT_BITS])),
		.rdata (ram_rdata)
	);

	// lanes, odometer step and best entry lookup
	always_comb begin
		if (dims_q == '0) begin
			n_used = 3'd1;
		end else if (int'(dims_q) > NUM_DIMS) begin
			n_used = gsbt_pkg::DIMSEL_BITS'(NUM_DIMS);
		end else begin
			n_used = dims_q;
		end

		for (int d = 0; d < NUM_DIMS; d++) begin
			low_c[d]  = lows_q[LB*d +: CB];
			high_c[d] = highs_q[LB*d +: CB];
			step_c[d] = steps_q[LB*d +: CB];
			nxt_c[d]  = CW1'(pt_q[d]) + CW1'(step_c[d]);
			can_c[d]  = nxt_c[d] <= CW1'(high_c[d]);
		end

		carry   = 1'b1;
		fin_adv = 1'b0;
		for (int d = 0; d < NUM_DIMS; d++) begin
			pt_adv[d] = pt_q[d];
			if (carry && d < int'(n_used)) begin
				if (can_c[d]) begin
					pt_adv[d] = CB'(nxt_c[d]);
					carry     = 1'b0;
				end else if (d == int'(n_used) - 1) begin
					fin_adv = 1'b1;
					carry   = 1'b0;
				end else begin
					pt_adv[d] = low_c[d];
				end
			end
		end

		rd_ent    = (fwd_vld_q && fwd_addr_q == addr_s1) ? fwd_data_q : ram_rdata;
		ent       = (slot_ok && vld_q[addr_s1]) ? rd_ent : '0;
		eff_score = ent[SB-1:0];
		for (int d = 0; d < NUM_DIMS; d++) begin
			eff_pt[d] = ent[SB + CB*d +: CB];
		end

		wr_ent[SB-1:0] = score_s1;
		for (int d = 0; d < NUM_DIMS; d++) begin
			wr_ent[SB + CB*d +: CB] = pt_q[d];
		end
	end

	// item processing
	always_comb begin
		pt_nxt  = pt_q;
		out_pt  = pt_q;
		cnt_nxt = cnt_q;
		fin     = 1'b0;
		imp     = 1'b0;
		we      = 1'b0;
		clr     = 1'b0;
		grade   = slot_ok ? eff_score : '0;
		unique case (action_s1)
			gsbt_pkg::ACT_RESTART: begin
				pt_nxt  = low_c;
				out_pt  = low_c;
				cnt_nxt = '0;
				clr     = 1'b1;
				grade   = '0;
			end
			gsbt_pkg::ACT_ADVANCE: begin
				pt_nxt = pt_adv;
				out_pt = pt_adv;
				fin    = fin_adv;
				if (!fin_adv && cnt_q != '1) begin
					cnt_nxt = cnt_q + gsbt_pkg::COUNT_BITS'(1);
				end
			end
			gsbt_pkg::ACT_REPORT: begin
				if (slot_ok && score_s1 > eff_score) begin
					imp   = 1'b1;
					we    = 1'b1;
					grade = score_s1;
				end
			end
			gsbt_pkg::ACT_READ: begin
				for (int d = 0; d < NUM_DIMS; d++) begin
					out_pt[d] = slot_ok ? eff_pt[d] : '0;
				end
			end
			default: ;
		endcase

		res_data = '0;
		for (int d = 0; d < gsbt_pkg::LANE_DIMS; d++) begin
			if (d < NUM_DIMS) begin
				res_data[LB*d +: LB] = LB'(out_pt[d]);
			end
		end
		res_data[LB*gsbt_pkg::LANE_DIMS +: SB] = grade;
		res_data[LB*gsbt_pkg::LANE_DIMS + SB +: gsbt_pkg::COUNT_BITS] = cnt_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
			for (int d = 0; d < NUM_DIMS; d++) begin
				pt_q[d] <= '0;
			end
			cnt_q     <= '0;
			vld_q     <= '0;
			fwd_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= s_axis_tvalid;
			out_vld_q <= vld_s1;
			if (vld_s1) begin
				pt_q  <= pt_nxt;
				cnt_q <= cnt_nxt;
				if (clr) begin
					vld_q     <= '0;
					fwd_vld_q <= 1'b0;
				end else if (we) begin
					vld_q[addr_s1] <= 1'b1;
					fwd_vld_q      <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			action_s1 <= s_axis_tuser[gsbt_pkg::ACTION_BITS-1:0];
			slot_s1   <= s_axis_tuser[gsbt_pkg::ACTION_BITS +: gsbt_pkg::SLOT_BITS];
			score_s1  <= s_axis_tdata;
		end
		if (proc) begin
			out_data_q <= res_data;
			out_user_q[gsbt_pkg::USER_FINISHED] <= fin;
			out_user_q[gsbt_pkg::USER_IMPROVED] <= imp;
			if (we) begin
				fwd_addr_q <= addr_s1;
				fwd_data_q <= wr_ent;
			end
		end
	end

endmodule

[hdl/gsbt_checker.sv]
// port-level checks for the grid sweep best tracker, bound to the top level
module gsbt_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [gsbt_pkg::M_TDATA_BITS-1:0] m_axis_tdata,
	input logic [gsbt_pkg::M_TUSER_BITS-1:0] m_axis_tuser
);

	// held result stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
	else $error("stalled result changed");

	// input side only waits on a stalled output
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid || m_axis_tready |-> s_axis_tready)
	else $error("input stalled without output stall");

	// an accepted item leaves a result once it has passed stage 1 and the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
	else $error("result missing after accept");

	// an item never both finishes the sweep and improves a best
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[gsbt_pkg::USER_FINISHED]
			&& m_axis_tuser[gsbt_pkg::USER_IMPROVED]))
	else $error("finished and improved together");

endmodule

bind grid_sweep_best_tracker gsbt_checker u_gsbt_checker (.*);

[tb/tb_grid_sweep_best_tracker.sv]
// testbench for grid_sweep_best_tracker: directed and random stream traffic checked against a sweep predictor
module tb_grid_sweep_best_tracker;
	timeunit 1ns;
	timeprecision 1ps;
	import gsbt_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int PHASES     = 12;
	localparam int PHASE_CMDS = 60;
	localparam int SLOTS      = NUM_SLOTS_DEF;

	typedef struct packed {
		action_t                act;
		logic [SLOT_BITS-1:0]   slot;
		logic [SCORE_BITS-1:0]  score;
	} sweep_cmd_t;

	typedef struct packed {
		logic [LANE_DIMS-1:0][LANE_BITS-1:0] coord;
		logic [SCORE_BITS-1:0]               grade;
		logic                                finished;
		logic                                improved;
		logic [COUNT_BITS-1:0]               steps;
	} sweep_res_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [S_TDATA_BITS-1:0]  s_axis_tdata = '0;
	logic [S_TUSER_BITS-1:0]  s_axis_tuser = '0;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic [M_TDATA_BITS-1:0]  m_axis_tdata;
	logic [M_TUSER_BITS-1:0]  m_axis_tuser;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	sweep_cmd_t pending_cmds [$];
	sweep_res_t predicted_results [$];
	int         err_cnt = 0;
	int         idle_cycles = 0;
	int         send_gap = 0;
	int         recv_gap = 0;
	bit         no_idle = 1'b0;

	// predictor copy of the block state and registers
	logic signed [LANE_BITS-1:0]  cur_pt [LANE_DIMS] = '{default: '0};
	logic signed [SCORE_BITS-1:0] slot_best [SLOTS] = '{default: '0};
	logic [CFG_DATA_BITS-1:0]     slot_pt [SLOTS] = '{default: '0};
	logic [COUNT_BITS-1:0]        adv_cnt = '0;
	logic [CFG_DATA_BITS-1:0]     lows_r = '0;
	logic [CFG_DATA_BITS-1:0]     highs_r = '0;
	logic [CFG_DATA_BITS-1:0]     steps_r = DIM_STEPS_RST;
	logic [DIMSEL_BITS-1:0]       dims_r = DIMS_IN_USE_RST;

	grid_sweep_best_tracker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic sweep_res_t predict_sweep(sweep_cmd_t c);
		sweep_res_t r;
		int n;
		int nxt;
		bit stop;
		bit moved;
		r = '0;
		stop = 1'b0;
		moved = 1'b0;
		case (c.act)
		ACT_RESTART: begin
			for (int d = 0; d < LANE_DIMS; d++)
				cur_pt[d] = lows_r[LANE_BITS*d +: LANE_BITS];
			for (int s = 0; s < SLOTS; s++) begin
				slot_best[s] = '0;
				slot_pt[s] = '0;
			end
			adv_cnt = '0;
		end
		ACT_ADVANCE: begin
			n = (dims_r == 0) ? 1 : ((dims_r > NUM_DIMS_DEF) ? NUM_DIMS_DEF : int'(dims_r));
			for (int d = 0; d < n && !stop; d++) begin
				nxt = int'(cur_pt[d]) + int'($signed(steps_r[LANE_BITS*d +: LANE_BITS]));
				if (nxt <= int'($signed(highs_r[LANE_BITS*d +: LANE_BITS]))) begin
					cur_pt[d] = nxt[LANE_BITS-1:0];
					moved = 1'b1;
					stop = 1'b1;
				end else if (d == n - 1) begin
					stop = 1'b1;
				end else begin
					cur_pt[d] = lows_r[LANE_BITS*d +: LANE_BITS];
				end
			end
			if (moved) begin
				if (adv_cnt != '1)
					adv_cnt = adv_cnt + 1;
			end else begin
				r.finished = 1'b1;
			end
		end
		ACT_REPORT: begin
			if ($signed(c.score) > slot_best[c.slot]) begin
				slot_best[c.slot] = c.score;
				slot_pt[c.slot] = {cur_pt[3], cur_pt[2], cur_pt[1], cur_pt[0]};
				r.improved = 1'b1;
			end
		end
		default: ;
		endcase
		r.grade = slot_best[c.slot];
		r.coord = (c.act == ACT_READ) ? slot_pt[c.slot] :
			{cur_pt[3], cur_pt[2], cur_pt[1], cur_pt[0]};
		r.steps = adv_cnt;
		return r;
	endfunction

	function automatic void compare_result(sweep_res_t want, sweep_res_t got);
		logic [31:0] w [8];
		logic [31:0] g [8];
		string fname [8] = '{"coord_0", "coord_1", "coord_2", "coord_3", "best_grade",
			"sweep_finished", "improved", "steps_taken"};
		for (int d = 0; d < LANE_DIMS; d++) begin
			w[d] = 32'(want.coord[d]);
			g[d] = 32'(got.coord[d]);
		end
		w[4] = want.grade;
		g[4] = got.grade;
		w[5] = 32'(want.finished);
		g[5] = 32'(got.finished);
		w[6] = 32'(want.improved);
		g[6] = 32'(got.improved);
		w[7] = want.steps;
		g[7] = got.steps;
		for (int i = 0; i < 8; i++) begin
			if (w[i] !== g[i]) begin
				err_cnt++;
				$display("%0t ns: %s mismatch, expected %h, actual %h",
					$time, fname[i], w[i], g[i]);
			end
		end
	endfunction

	function automatic void add_cmd(action_t a, logic [SLOT_BITS-1:0] s,
			logic [SCORE_BITS-1:0] sc);
		sweep_cmd_t c;
		c.act = a;
		c.slot = s;
		c.score = sc;
		pending_cmds = {pending_cmds, c};
	endfunction

	function automatic logic [SCORE_BITS-1:0] pick_score();
		logic [SCORE_BITS-1:0] v;
		case ($urandom_range(0, 3))
		0: v = $urandom();
		1: v = $urandom_range(1, 32'h0010_0000);
		2: v = -$urandom_range(0, 32'h0001_0000);
		default: begin
			case ($urandom_range(0, 3))
			0: v = 32'h7FFF_FFFF;
			1: v = 32'h8000_0000;
			2: v = 32'h0000_0000;
			default: v = 32'hFFFF_FFFF;
			endcase
		end
		endcase
		return v;
	endfunction

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || s_axis_tvalid || predicted_results.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	// sender
	always @(posedge clk) begin
		sweep_cmd_t c;
		if (arst_n && !(s_axis_tvalid && !s_axis_tready)) begin
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (!no_idle && pending_cmds.size() != 0 && $urandom_range(0, 5) == 0) begin
				send_gap = $urandom_range(0, 3);
				s_axis_tvalid <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				c = pending_cmds.pop_front();
				s_axis_tvalid <= 1'b1;
				// tuser: action, score_slot
				s_axis_tuser <= {c.slot, c.act};
				s_axis_tdata <= c.score;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		if (arst_n) begin
			if (recv_gap > 0) begin
				recv_gap--;
				m_axis_tready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 4) == 0) begin
				recv_gap = $urandom_range(0, 3);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// checker and predictor feed
	always @(posedge clk) begin
		sweep_res_t got;
		sweep_res_t want;
		sweep_cmd_t c;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.coord = m_axis_tdata[63:0];
				got.grade = m_axis_tdata[95:64];
				got.steps = m_axis_tdata[127:96];
				got.finished = m_axis_tuser[USER_FINISHED];
				got.improved = m_axis_tuser[USER_IMPROVED];
				if (predicted_results.size() == 0) begin
					err_cnt++;
					$display("%0t ns: unexpected result item, expected none, actual %h %h",
						$time, m_axis_tdata, m_axis_tuser);
				end else begin
					compare_result(predicted_results.pop_front(), got);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_DIM_LOWS:    lows_r = cfg_data;
				REG_DIM_HIGHS:   highs_r = cfg_data;
				REG_DIM_STEPS:   steps_r = cfg_data;
				REG_DIMS_IN_USE: dims_r = cfg_data[DIMSEL_BITS-1:0];
				default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				c.act = s_axis_tuser[ACTION_BITS-1:0];
				c.slot = s_axis_tuser[ACTION_BITS +: SLOT_BITS];
				c.score = s_axis_tdata;
				want = predict_sweep(c);
				predicted_results = {predicted_results, want};
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t ns: no progress for %0d cycles", $time, IDLE_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [CFG_DATA_BITS-1:0] lo_v;
		logic [CFG_DATA_BITS-1:0] hi_v;
		logic [CFG_DATA_BITS-1:0] st_v;
		logic [CFG_DATA_BITS-1:0] dims_v;
		int lo;
		int hi;
		int st;
		int style;
		int r;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset registers: all highs zero, so the first advance finishes at once
		add_cmd(ACT_READ, 3'd0, 32'h1234_5678);
		add_cmd(ACT_ADVANCE, 3'd1, 32'h0);
		add_cmd(ACT_REPORT, 3'd7, 32'h7FFF_FFFF);
		add_cmd(ACT_REPORT, 3'd7, 32'h0000_0001);
		add_cmd(ACT_REPORT, 3'd0, 32'h8000_0000);
		add_cmd(ACT_REPORT, 3'd0, 32'h0000_0000);
		add_cmd(ACT_READ, 3'd7, 32'hFFFF_FFFF);
		wait_drained();

		// small grid of six points; first advance runs on the old point
		write_reg(REG_DIM_LOWS, 64'h000A_0005_0000_FFFD);
		write_reg(REG_DIM_HIGHS, 64'h000A_0005_0001_0003);
		write_reg(REG_DIM_STEPS, 64'h0001_0001_0001_0003);
		write_reg(REG_DIMS_IN_USE, 64'd4);
		@(negedge clk);
		add_cmd(ACT_ADVANCE, 3'd2, 32'h0);
		add_cmd(ACT_RESTART, 3'd5, 32'hAAAA_5555);
		add_cmd(ACT_READ, 3'd7, 32'h0);
		for (int i = 0; i < 6; i++) begin
			add_cmd(ACT_ADVANCE, 3'(i), 32'h0);
			if (i == 1)
				add_cmd(ACT_REPORT, 3'd3, 32'h0000_0001);
			if (i == 2)
				add_cmd(ACT_REPORT, 3'd3, 32'hFFFF_FFFF);
			if (i == 3)
				add_cmd(ACT_REPORT, 3'd5, 32'h0001_0000);
		end
		add_cmd(ACT_READ, 3'd3, 32'h0);
		add_cmd(ACT_READ, 3'd5, 32'h0);
		wait_drained();

		for (int phase = 0; phase < PHASES; phase++) begin
			no_idle = (phase >= PHASES - 2) || (phase % 5 == 4);
			style = phase % 4;
			for (int d = 0; d < LANE_DIMS; d++) begin
				case (style)
				0: begin
					lo = $urandom_range(0, 40) - 20;
					hi = lo + $urandom_range(0, 3);
					st = $urandom_range(1, 2);
				end
				1: begin
					lo = $urandom();
					hi = $urandom();
					st = $urandom();
				end
				2: begin
					lo = 32'h8000;
					hi = 32'h7FFF;
					st = $urandom_range(0, 1) ? 32'h7FFF : 32'h8000;
				end
				default: begin
					lo = $urandom_range(0, 20) - 10;
					hi = $urandom_range(0, 20) - 10;
					st = -$urandom_range(0, 3);
				end
				endcase
				lo_v[LANE_BITS*d +: LANE_BITS] = lo[LANE_BITS-1:0];
				hi_v[LANE_BITS*d +: LANE_BITS] = hi[LANE_BITS-1:0];
				st_v[LANE_BITS*d +: LANE_BITS] = st[LANE_BITS-1:0];
			end
			dims_v = {$urandom(), $urandom()};
			dims_v[DIMSEL_BITS-1:0] = (style == 0) ? DIMSEL_BITS'($urandom_range(0, 2)) :
				DIMSEL_BITS'($urandom_range(0, 7));
			write_reg(REG_DIM_LOWS, lo_v);
			write_reg(REG_DIM_HIGHS, hi_v);
			write_reg(REG_DIM_STEPS, st_v);
			write_reg(REG_DIMS_IN_USE, dims_v);
			@(negedge clk);
			if ($urandom_range(0, 3) != 0)
				add_cmd(ACT_RESTART, 3'($urandom_range(0, 7)), $urandom());
			for (int i = 0; i < PHASE_CMDS; i++) begin
				r = $urandom_range(0, 19);
				if (r == 0)
					add_cmd(ACT_RESTART, 3'($urandom_range(0, 7)), $urandom());
				else if (r <= 10)
					add_cmd(ACT_ADVANCE, 3'($urandom_range(0, 7)), $urandom());
				else if (r <= 16)
					add_cmd(ACT_REPORT, 3'($urandom_range(0, 7)), pick_score());
				else
					add_cmd(ACT_READ, 3'($urandom_range(0, 7)), $urandom());
			end
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
